// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// S-box tables, GF(2^8) helpers and round functions shared by the datapath.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int SchedWords = 4 * (NumRounds + 1);

   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   localparam logic [7:0] RconInit = 8'h01;

   typedef logic [7:0]   byte_type;
   typedef logic [31:0]  word_type;
   typedef logic [127:0] state_type;

   // Forward S-box as a constant table.
   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Inverse S-box.
   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // Multiply by x modulo the AES polynomial 0x11b.
   function automatic byte_type gf_dbl(input byte_type a);
      gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of the state in FIPS order (byte 0 in the top bits).
   function automatic byte_type get_byte(input state_type s, input int k);
      get_byte = s[127 - 8*k -: 8];
   endfunction

   function automatic word_type sub_word(input word_type w);
      sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction

   // SubBytes and ShiftRows together (forward).
   function automatic state_type fwd_sub_shift(input state_type s);
      state_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = FWD_BOX[get_byte(s, 4*((c + r) % 4) + r)];
         end
      end
      fwd_sub_shift = t;
   endfunction

   // Inverse ShiftRows and inverse SubBytes together.
   function automatic state_type inv_shift_sub(input state_type s);
      state_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*((c + r) % 4) + r) -: 8] = INV_BOX[get_byte(s, 4*c + r)];
         end
      end
      inv_shift_sub = t;
   endfunction

   // Forward MixColumns.
   function automatic state_type fwd_mix(input state_type s);
      state_type t;
      byte_type  a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         t[127 - 32*c -: 32] = {
            gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3,
            gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3)};
      end
      fwd_mix = t;
   endfunction

   // Inverse MixColumns: premultiply by {05,00,04,00} then forward mix.
   function automatic state_type inv_mix(input state_type s);
      state_type t;
      byte_type  a0, a1, a2, a3, u, v;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         u = gf_dbl(gf_dbl(a0 ^ a2));
         v = gf_dbl(gf_dbl(a1 ^ a3));
         t[127 - 32*c -: 32] = {a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v};
      end
      inv_mix = fwd_mix(t);
   endfunction

endpackage

// ===== rtl/aes128_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher top level
// One 128-bit ECB block per transfer, encrypt or decrypt by command.
// ----------------------------------------------------------------------------
// The cipher is a 21-stage pipeline: an initial key-add stage, then two
// stages per round (substitution and shift, then mixing and key add; the
// last round only adds its key). One block enters every cycle unless the
// pipeline stalls or the key schedule is busy; a stall on the result side
// holds the whole pipeline. After reset and each key write, the key schedule
// expands one round key per cycle; no block is accepted until it is done.
module aes128_block_cipher_top
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low
);

   localparam int Stages = 2 * NumRounds + 1;

   state_type round_key [NumRounds + 1];
   logic      key_busy;
   logic      advance;

   state_type data_ff [Stages];
   logic      cmd_ff  [Stages];
   logic      vld_ff  [Stages];
   state_type data_in [Stages];

   aes_key_sched u_key (
      .clock     (clock),
      .reset     (reset),
      .key_we    (csr_we),
      .key_sel   (csr_index),
      .key_data  (csr_data),
      .round_key (round_key),
      .busy      (key_busy)
   );

   // The pipeline moves when the last stage is empty or being drained.
   assign advance   = !vld_ff[Stages - 1] || rsp_ready;
   assign req_ready = advance && !key_busy;

   // Stage logic: stage 0 adds the first key (the last one to decrypt); odd
   // stages substitute and shift; even stages mix and add the round key, the last only adds it.
   always_comb begin
      data_in[0] = {req_block_high, req_block_low} ^
                   (req_cmd ? round_key[NumRounds] : round_key[0]);
      for (int s = 1; s < Stages; s++) begin
         if (s % 2 == 1) begin
            data_in[s] = cmd_ff[s - 1] ? inv_shift_sub(data_ff[s - 1])
                                       : fwd_sub_shift(data_ff[s - 1]);
         end else if (s == Stages - 1) begin
            data_in[s] = data_ff[s - 1] ^
                         (cmd_ff[s - 1] ? round_key[0] : round_key[NumRounds]);
         end else begin
            data_in[s] = cmd_ff[s - 1]
               ? inv_mix(data_ff[s - 1] ^ round_key[NumRounds - s / 2])
               : fwd_mix(data_ff[s - 1]) ^ round_key[s / 2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid && req_ready;
         for (int s = 1; s < Stages; s++) vld_ff[s] <= vld_ff[s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff[0] <= data_in[0];
         cmd_ff[0]  <= req_cmd;
         for (int s = 1; s < Stages; s++) begin
            data_ff[s] <= data_in[s];
            cmd_ff[s]  <= cmd_ff[s - 1];
         end
      end
   end

   assign rsp_valid       = vld_ff[Stages - 1];
   assign rsp_result_high = data_ff[Stages - 1][127:64];
   assign rsp_result_low  = data_ff[Stages - 1][63:0];

endmodule

// ===== rtl/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and expands the 44-word round-key schedule, one
// round key (four words) per cycle after reset and after every key write.
// ----------------------------------------------------------------------------
module aes_key_sched
   import aes_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        key_we,
   input  logic                        key_sel,
   input  logic [63:0]                 key_data,
   output state_type                   round_key [NumRounds + 1],
   output logic                        busy
);

   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   state_type   rk_ff [NumRounds + 1];
   state_type   next_rk;
   logic [3:0]  step_ff, step_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic        run_ff, run_in;
   word_type    t, w0, w1, w2, w3;

   // Key registers; a write restarts the expansion.
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (key_we && !key_sel) key_high_in = key_data;
      if (key_we && key_sel) key_low_in = key_data;
   end

   // Next round key from the previous one.
   always_comb begin
      t  = sub_word({rk_ff[step_ff - 4'd1][23:0], rk_ff[step_ff - 4'd1][31:24]})
           ^ {rcon_ff, 24'h0};
      w0 = rk_ff[step_ff - 4'd1][127:96] ^ t;
      w1 = rk_ff[step_ff - 4'd1][95:64] ^ w0;
      w2 = rk_ff[step_ff - 4'd1][63:32] ^ w1;
      w3 = rk_ff[step_ff - 4'd1][31:0] ^ w2;
      next_rk = {w0, w1, w2, w3};
   end

   // Sequencer control.
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      rcon_in = rcon_ff;
      if (key_we) begin
         run_in  = 1'b1;
         step_in = 4'd1;
         rcon_in = RconInit;
      end else if (run_ff) begin
         rcon_in = gf_dbl(rcon_ff);
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(NumRounds)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         run_ff      <= 1'b1;
         step_ff     <= 4'd1;
         rcon_ff     <= RconInit;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         run_ff      <= run_in;
         step_ff     <= step_in;
         rcon_ff     <= rcon_in;
      end
   end

   // Round-key storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff[0] <= '0;
      end else if (key_we) begin
         rk_ff[0] <= {key_high_in, key_low_in};
      end else if (run_ff) begin
         rk_ff[step_ff] <= next_rk;
      end
   end

   assign round_key = rk_ff;
   assign busy      = run_ff;

endmodule
